// ===== hdl/afinv_pkg.sv =====
// Shared types, widths and helpers for the affine matrix inverse pipeline.
// No dependencies; every other file in hdl/ imports this package.
package afinv_pkg;

    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int COF_W  = 64;
    localparam int DET_W  = 97;
    localparam int DMAG_W = 96;
    localparam int LANES  = 9;

    localparam logic [DATA_W-1:0] POS_LIM = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_LIM = 32'h8000_0000;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [DET_W-1:0]  det_t;

    typedef struct packed {
        word_t in_r0c0;
        word_t in_r0c1;
        word_t in_r0c2;
        word_t in_r1c0;
        word_t in_r1c1;
        word_t in_r1c2;
        word_t in_r2c0;
        word_t in_r2c1;
        word_t in_r2c2;
        word_t in_shift_x;
        word_t in_shift_y;
        word_t in_shift_z;
    } afinv_in_t;

    typedef struct packed {
        word_t inv_r0c0;
        word_t inv_r0c1;
        word_t inv_r0c2;
        word_t inv_r1c0;
        word_t inv_r1c1;
        word_t inv_r1c2;
        word_t inv_r2c0;
        word_t inv_r2c1;
        word_t inv_r2c2;
        word_t inv_shift_x;
        word_t inv_shift_y;
        word_t inv_shift_z;
    } afinv_out_t;

    // cofactors and determinant, leaving the front end
    typedef struct packed {
        logic             vld;
        word_t [2:0]      shift;
        cof_t [LANES-1:0] cof;
        det_t             det;
    } det_res_t;

    // saturated inverse entries, leaving the divider
    typedef struct packed {
        logic              vld;
        logic              sing;
        word_t [2:0]       shift;
        word_t [LANES-1:0] r;
    } div_res_t;

    function automatic prod_t mul_ss(input word_t x, input word_t y);
        return prod_t'(x) * prod_t'(y);
    endfunction

    // clamp a sign and magnitude to the signed word range
    function automatic word_t sat_word(input logic ovf, input logic [DATA_W-1:0] mag,
                                       input logic neg);
        word_t res;
        if (neg) begin
            if (ovf || (mag > NEG_LIM)) res = word_t'(NEG_LIM);
            else res = word_t'(DATA_W'(0) - mag);
        end else begin
            if (ovf || (mag > POS_LIM)) res = word_t'(POS_LIM);
            else res = word_t'(mag);
        end
        return res;
    endfunction

endpackage

// ===== hdl/afinv_det.sv =====
// Front end: nine exact cofactors and the determinant, five register stages.
// Depends on afinv_pkg.
module afinv_det
    import afinv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      ce,
    input  logic      in_vld,
    input  afinv_in_t in_data,
    output det_res_t  res
);

    localparam int LO_W = 2 * DATA_W + 1;

    // cofactor i = m[PX]*m[PY] - m[QX]*m[QY], entries m[0]..m[8] in row-major order
    localparam int IDX_PX [LANES] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int IDX_PY [LANES] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int IDX_QX [LANES] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int IDX_QY [LANES] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
    localparam int IDX_DC [3]     = '{0, 3, 6};

    word_t m [LANES];

    assign m[0] = in_data.in_r0c0;
    assign m[1] = in_data.in_r0c1;
    assign m[2] = in_data.in_r0c2;
    assign m[3] = in_data.in_r1c0;
    assign m[4] = in_data.in_r1c1;
    assign m[5] = in_data.in_r1c2;
    assign m[6] = in_data.in_r2c0;
    assign m[7] = in_data.in_r2c1;
    assign m[8] = in_data.in_r2c2;

    logic [4:0]       vld_reg;
    word_t [2:0]      a_shift_reg, b_shift_reg, c_shift_reg, d_shift_reg, e_shift_reg;
    word_t            a_row_reg [3];
    word_t            b_row_reg [3];
    prod_t            a_pp_reg [LANES];
    prod_t            a_pq_reg [LANES];
    cof_t             b_cof_reg [LANES];
    cof_t             c_cof_reg [LANES];
    cof_t             d_cof_reg [LANES];
    cof_t [LANES-1:0] e_cof_reg;
    prod_t            c_hi_reg [3];
    logic signed [LO_W-1:0] c_lo_reg [3];
    det_t             d_term_reg [3];
    det_t             e_det_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            // stage A: cofactor products
            for (int i = 0; i < LANES; i++) begin
                a_pp_reg[i] <= mul_ss(m[IDX_PX[i]], m[IDX_PY[i]]);
                a_pq_reg[i] <= mul_ss(m[IDX_QX[i]], m[IDX_QY[i]]);
            end
            for (int j = 0; j < 3; j++) a_row_reg[j] <= m[j];
            a_shift_reg <= {in_data.in_shift_z, in_data.in_shift_y, in_data.in_shift_x};

            // stage B: cofactors, exact in 64 bits
            for (int i = 0; i < LANES; i++) b_cof_reg[i] <= a_pp_reg[i] - a_pq_reg[i];
            b_row_reg   <= a_row_reg;
            b_shift_reg <= a_shift_reg;

            // stage C: first-row entry times cofactor, split in two 32-bit halves
            for (int j = 0; j < 3; j++) begin
                c_hi_reg[j] <= mul_ss(b_row_reg[j],
                                      word_t'(b_cof_reg[IDX_DC[j]][COF_W-1:DATA_W]));
                c_lo_reg[j] <= LO_W'(b_row_reg[j]) *
                               LO_W'($signed({1'b0, b_cof_reg[IDX_DC[j]][DATA_W-1:0]}));
            end
            c_cof_reg   <= b_cof_reg;
            c_shift_reg <= b_shift_reg;

            // stage D: recombine halves
            for (int j = 0; j < 3; j++) begin
                d_term_reg[j] <= (det_t'(c_hi_reg[j]) <<< DATA_W) + det_t'(c_lo_reg[j]);
            end
            d_cof_reg   <= c_cof_reg;
            d_shift_reg <= c_shift_reg;

            // stage E: determinant
            e_det_reg <= d_term_reg[0] + d_term_reg[1] + d_term_reg[2];
            for (int i = 0; i < LANES; i++) e_cof_reg[i] <= d_cof_reg[i];
            e_shift_reg <= d_shift_reg;
        end
    end

    assign res.vld   = vld_reg[4];
    assign res.shift = e_shift_reg;
    assign res.cof   = e_cof_reg;
    assign res.det   = e_det_reg;

endmodule

// ===== hdl/afinv_div.sv =====
// Nine-lane pipelined restoring divider: entry = round(cof * 2^(2F) / det),
// one quotient bit per stage, saturated at the end. Depends on afinv_pkg.
module afinv_div
    import afinv_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     ce,
    input  det_res_t din,
    output div_res_t dout
);

    localparam int NUM_W = ((COF_W + 2 * FRAC_BITS) > DMAG_W ?
                            (COF_W + 2 * FRAC_BITS) : DMAG_W) + 1;
    localparam int DEN_W = DMAG_W + 1;

    // prep stages
    logic [1:0]        pre_vld_reg;
    logic              p1_sing_reg, p2_sing_reg;
    word_t [2:0]       p1_shift_reg, p2_shift_reg;
    logic [COF_W-1:0]  p1_cmag_reg [LANES];
    logic [LANES-1:0]  p1_cneg_reg, p2_neg_reg;
    logic [DMAG_W-1:0] p1_dmag_reg;
    logic              p1_dneg_reg;
    logic [NUM_W-1:0]  p2_num_reg [LANES];
    logic [DEN_W-1:0]  p2_den_reg;

    // step k holds the state after k quotient bits
    logic [DATA_W:0]   st_vld_reg;
    logic              st_sing_reg  [DATA_W+1];
    word_t [2:0]       st_shift_reg [DATA_W+1];
    logic [DEN_W-1:0]  st_den_reg   [DATA_W+1];
    logic [LANES-1:0]  st_ovf_reg   [DATA_W+1];
    logic [LANES-1:0]  st_neg_reg   [DATA_W+1];
    logic [DEN_W-1:0]  rem_reg      [DATA_W+1][LANES];
    logic [DATA_W-1:0] nlo_reg      [DATA_W+1][LANES];
    logic [DATA_W-1:0] q_reg        [DATA_W+1][LANES];

    logic [DEN_W:0]    trial [1:DATA_W][LANES];
    logic              take  [1:DATA_W][LANES];

    logic              out_vld_reg, out_sing_reg;
    word_t [2:0]       out_shift_reg;
    word_t [LANES-1:0] out_r_reg;

    always_comb begin
        for (int k = 1; k <= DATA_W; k++) begin
            for (int i = 0; i < LANES; i++) begin
                trial[k][i] = {rem_reg[k-1][i], nlo_reg[k-1][i][DATA_W-1]};
                take[k][i]  = trial[k][i] >= {1'b0, st_den_reg[k-1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_vld_reg <= '0;
            st_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end else if (ce) begin
            pre_vld_reg <= {pre_vld_reg[0], din.vld};
            st_vld_reg  <= {st_vld_reg[DATA_W-1:0], pre_vld_reg[1]};
            out_vld_reg <= st_vld_reg[DATA_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            // P1: magnitudes and signs
            for (int i = 0; i < LANES; i++) begin
                p1_cmag_reg[i] <= din.cof[i][COF_W-1] ? COF_W'(COF_W'(0) - din.cof[i])
                                                      : COF_W'(din.cof[i]);
                p1_cneg_reg[i] <= din.cof[i][COF_W-1];
            end
            p1_dmag_reg  <= din.det[DET_W-1] ? DMAG_W'(DET_W'(0) - din.det)
                                             : DMAG_W'(din.det);
            p1_dneg_reg  <= din.det[DET_W-1];
            p1_sing_reg  <= (din.det == '0);
            p1_shift_reg <= din.shift;

            // P2: numerator 2*|cof|*2^(2F) + |det| over 2*|det| rounds to nearest
            for (int i = 0; i < LANES; i++) begin
                p2_num_reg[i] <= (NUM_W'(p1_cmag_reg[i]) << (2 * FRAC_BITS + 1)) +
                                 NUM_W'(p1_dmag_reg);
            end
            p2_neg_reg   <= p1_cneg_reg ^ {LANES{p1_dneg_reg}};
            p2_den_reg   <= {p1_dmag_reg, 1'b0};
            p2_sing_reg  <= p1_sing_reg;
            p2_shift_reg <= p1_shift_reg;

            // step 0: overflow check and initial remainder
            for (int i = 0; i < LANES; i++) begin
                st_ovf_reg[0][i] <= p2_num_reg[i][NUM_W-1:DATA_W] >= p2_den_reg;
                rem_reg[0][i]    <= DEN_W'(p2_num_reg[i][NUM_W-1:DATA_W]);
                nlo_reg[0][i]    <= p2_num_reg[i][DATA_W-1:0];
                q_reg[0][i]      <= '0;
            end
            st_neg_reg[0]   <= p2_neg_reg;
            st_den_reg[0]   <= p2_den_reg;
            st_sing_reg[0]  <= p2_sing_reg;
            st_shift_reg[0] <= p2_shift_reg;

            // quotient steps, one bit each
            for (int k = 1; k <= DATA_W; k++) begin
                for (int i = 0; i < LANES; i++) begin
                    rem_reg[k][i] <= take[k][i] ?
                                     DEN_W'(trial[k][i] - {1'b0, st_den_reg[k-1]}) :
                                     trial[k][i][DEN_W-1:0];
                    nlo_reg[k][i] <= nlo_reg[k-1][i] << 1;
                    q_reg[k][i]   <= {q_reg[k-1][i][DATA_W-2:0], take[k][i]};
                end
                st_ovf_reg[k]   <= st_ovf_reg[k-1];
                st_neg_reg[k]   <= st_neg_reg[k-1];
                st_den_reg[k]   <= st_den_reg[k-1];
                st_sing_reg[k]  <= st_sing_reg[k-1];
                st_shift_reg[k] <= st_shift_reg[k-1];
            end

            // saturate
            for (int i = 0; i < LANES; i++) begin
                out_r_reg[i] <= sat_word(st_ovf_reg[DATA_W][i], q_reg[DATA_W][i],
                                         st_neg_reg[DATA_W][i]);
            end
            out_sing_reg  <= st_sing_reg[DATA_W];
            out_shift_reg <= st_shift_reg[DATA_W];
        end
    end

    assign dout.vld   = out_vld_reg;
    assign dout.sing  = out_sing_reg;
    assign dout.shift = out_shift_reg;
    assign dout.r     = out_r_reg;

endmodule

// ===== hdl/afinv_xlat.sv =====
// Back end: inverse translation -(inv * t) with rounding and saturation,
// singular override, four register stages. Depends on afinv_pkg.
module afinv_xlat
    import afinv_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       ce,
    input  div_res_t   din,
    output logic       out_vld,
    output afinv_out_t out_data
);

    localparam int SUM_W = PROD_W + 2;
    localparam logic [SUM_W:0] HALF = (SUM_W + 1)'(1) << (FRAC_BITS - 1);
    localparam word_t ONE = word_t'(DATA_W'(1) << FRAC_BITS);

    logic [3:0]          vld_reg;
    logic [2:0]          sing_reg;
    word_t [LANES-1:0]   x1_r_reg, x2_r_reg, x3_r_reg;
    prod_t               x1_p_reg [3][3];
    logic signed [SUM_W-1:0] x2_s_reg [3];
    logic [SUM_W-1:0]    x3_mag_reg [3];
    logic [2:0]          x3_neg_reg;
    word_t [LANES-1:0]   o_r_reg;
    word_t [2:0]         o_t_reg;

    logic [SUM_W:0]      rnd [3];
    logic [SUM_W:0]      shr [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rnd[i] = (SUM_W + 1)'(x3_mag_reg[i]) + HALF;
            shr[i] = rnd[i] >> FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[2:0], din.vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    x1_p_reg[i][j] <= mul_ss(din.r[i*3+j], din.shift[j]);
                end
            end
            x1_r_reg <= din.r;

            for (int i = 0; i < 3; i++) begin
                x2_s_reg[i] <= SUM_W'(x1_p_reg[i][0]) + SUM_W'(x1_p_reg[i][1]) +
                               SUM_W'(x1_p_reg[i][2]);
            end
            x2_r_reg <= x1_r_reg;

            // the negated sum is negative exactly when the sum is positive
            for (int i = 0; i < 3; i++) begin
                x3_mag_reg[i] <= x2_s_reg[i][SUM_W-1] ? SUM_W'(SUM_W'(0) - x2_s_reg[i])
                                                      : SUM_W'(x2_s_reg[i]);
                x3_neg_reg[i] <= !x2_s_reg[i][SUM_W-1] && (x2_s_reg[i] != '0);
            end
            x3_r_reg <= x2_r_reg;

            // singular input: identity with zero translation
            for (int i = 0; i < 3; i++) begin
                o_t_reg[i] <= sing_reg[2] ? word_t'(0) :
                              sat_word(|shr[i][SUM_W:DATA_W], shr[i][DATA_W-1:0],
                                       x3_neg_reg[i]);
            end
            for (int i = 0; i < LANES; i++) begin
                if (sing_reg[2]) o_r_reg[i] <= (i % 4 == 0) ? ONE : word_t'(0);
                else o_r_reg[i] <= x3_r_reg[i];
            end

            sing_reg <= {sing_reg[1:0], din.sing};
        end
    end

    assign out_vld = vld_reg[3];

    assign out_data.inv_r0c0    = o_r_reg[0];
    assign out_data.inv_r0c1    = o_r_reg[1];
    assign out_data.inv_r0c2    = o_r_reg[2];
    assign out_data.inv_r1c0    = o_r_reg[3];
    assign out_data.inv_r1c1    = o_r_reg[4];
    assign out_data.inv_r1c2    = o_r_reg[5];
    assign out_data.inv_r2c0    = o_r_reg[6];
    assign out_data.inv_r2c1    = o_r_reg[7];
    assign out_data.inv_r2c2    = o_r_reg[8];
    assign out_data.inv_shift_x = o_t_reg[0];
    assign out_data.inv_shift_y = o_t_reg[1];
    assign out_data.inv_shift_z = o_t_reg[2];

endmodule

// ===== hdl/affine_matrix_inverse.sv =====
// Top level of the affine transform inverse: front end, divider, back end
// and output skid stage. Depends on afinv_pkg, afinv_det, afinv_div, afinv_xlat.
//
//   channel   ports                        payload
//   input     s_valid, s_ready, s_data     afinv_in_t  (L and t, Q16.16)
//   result    m_valid, m_ready, m_data     afinv_out_t (inverse L and t)
//
// One transform per cycle sustained while the skid stage is empty. Input transfer
// to m_valid passes 5 front-end stages, 36 divider stages (prep, step 0, the
// quotient steps and saturation), 4 back-end stages and the output register.
// Reset clears only the valid bits. A stalled output holds in place while the
// pipeline keeps moving until a second finished result fills the skid stage.
module affine_matrix_inverse
    import afinv_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  afinv_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output afinv_out_t m_data
);

    logic       ce;
    det_res_t   det_res;
    div_res_t   div_res;
    logic       fin_vld;
    afinv_out_t fin_data;

    logic       out_vld_reg, skid_vld_reg;
    afinv_out_t out_data_reg, skid_data_reg;

    assign ce      = ~skid_vld_reg;
    assign s_ready = ce;

    afinv_det u_det (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .in_vld  (s_valid),
        .in_data (s_data),
        .res     (det_res)
    );

    afinv_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .din     (det_res),
        .dout    (div_res)
    );

    afinv_xlat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_xlat (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .din      (div_res),
        .out_vld  (fin_vld),
        .out_data (fin_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_ready) begin
            // output free: drain skid first, else take the pipeline tail
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg  <= fin_vld;
            end
        end else if (ce && fin_vld) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_ready) begin
            out_data_reg <= skid_vld_reg ? skid_data_reg : fin_data;
        end
        if (ce) begin
            skid_data_reg <= fin_data;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== test/affine_matrix_inverse_tb.sv =====
// Self-checking bench for affine_matrix_inverse: random and directed transforms,
// predicted inverse compared field by field. Depends on afinv_pkg and the RTL.
module affine_matrix_inverse_tb
    import afinv_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int LATENCY = 46;
    localparam int N_RANDOM = 1150;

    typedef logic [127:0] u128_t;
    typedef logic signed [127:0] s128_t;

    function automatic word_t clamp_word(u128_t mag, bit neg);
        word_t res;
        if (neg) res = (mag > u128_t'(32'h8000_0000)) ? word_t'(NEG_LIM) : word_t'(-mag[31:0]);
        else res = (mag > u128_t'(32'h7FFF_FFFF)) ? word_t'(POS_LIM) : word_t'(mag[31:0]);
        return res;
    endfunction

    function automatic u128_t abs128(s128_t v);
        return v[127] ? u128_t'(-v) : u128_t'(v);
    endfunction

    // cofactor * 2^(2F) / det, nearest with ties away from zero
    function automatic word_t div_nearest(s128_t cof, s128_t det);
        u128_t n, d, q;
        n = abs128(cof) << (2 * FRAC);
        d = abs128(det);
        q = ((n << 1) + d) / (d << 1);
        return clamp_word(q, cof[127] != det[127]);
    endfunction

    function automatic afinv_out_t predict_inverse(afinv_in_t x);
        word_t [11:0] w;
        word_t [11:0] res;
        s128_t m[12];
        s128_t cof[9];
        s128_t det, s, r;
        w = x;
        // packed order: index 11 is in_r0c0
        for (int i = 0; i < 12; i++) m[i] = w[11 - i];
        cof[0] = m[4] * m[8] - m[5] * m[7];
        cof[1] = m[2] * m[7] - m[1] * m[8];
        cof[2] = m[1] * m[5] - m[2] * m[4];
        cof[3] = m[5] * m[6] - m[3] * m[8];
        cof[4] = m[0] * m[8] - m[2] * m[6];
        cof[5] = m[2] * m[3] - m[0] * m[5];
        cof[6] = m[3] * m[7] - m[4] * m[6];
        cof[7] = m[1] * m[6] - m[0] * m[7];
        cof[8] = m[0] * m[4] - m[1] * m[3];
        det = m[0] * cof[0] + m[1] * cof[3] + m[2] * cof[6];
        res = '0;
        if (det == 0) begin
            res[11] = word_t'(1 << FRAC);
            res[7] = word_t'(1 << FRAC);
            res[3] = word_t'(1 << FRAC);
        end else begin
            for (int i = 0; i < 9; i++) res[11 - i] = div_nearest(cof[i], det);
            for (int i = 0; i < 3; i++) begin
                s = 0;
                for (int j = 0; j < 3; j++) begin
                    r = res[11 - (i * 3 + j)];
                    s = s + r * m[9 + j];
                end
                s = -s;
                res[2 - i] = clamp_word((abs128(s) + (u128_t'(1) << (FRAC - 1))) >> FRAC,
                                        s[127]);
            end
        end
        return afinv_out_t'(res);
    endfunction

    class inverse_board;
        afinv_out_t expected_inverses[$];
        int errors = 0;

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note(afinv_in_t x);
            expected_inverses.push_back(predict_inverse(x));
        endfunction

        task check(afinv_out_t got);
            afinv_out_t want;
            word_t [11:0] gw, ww;
            if (expected_inverses.size() == 0) begin
                report("result with no transform pending");
                return;
            end
            want = expected_inverses.pop_front();
            gw = got;
            ww = want;
            for (int i = 11; i >= 0; i--)
                if (gw[i] !== ww[i])
                    report($sformatf("field %0d: got %h want %h", 11 - i, gw[i], ww[i]));
        endtask

        function int pending();
            return expected_inverses.size();
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    afinv_in_t  s_data;
    logic       m_valid;
    logic       m_ready;
    afinv_out_t m_data;

    inverse_board sb = new;

    affine_matrix_inverse u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note(s_data);
            if (m_valid && m_ready) sb.check(m_data);
        end
    end

    function automatic word_t near_one(int spread);
        return word_t'((1 << FRAC) + $signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic afinv_in_t random_transform();
        word_t [11:0] w;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++) w[i] = $urandom;
        if (kind >= 3) begin
            // well-conditioned: scaled near-identity with modest off-diagonals
            for (int i = 0; i < 9; i++)
                w[11 - i] = word_t'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
            w[11] = near_one(1 << 15);
            w[7] = near_one(1 << 15);
            w[3] = near_one(1 << 15);
            if (kind == 9) w[7] = -w[7];
            if (kind >= 7)
                for (int i = 0; i < 3; i++) w[i] = word_t'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        end else if (kind == 2) begin
            // make singular: copy one row onto another
            for (int c = 0; c < 3; c++) w[11 - (3 + c)] = w[11 - c];
        end
        return afinv_in_t'(w);
    endfunction

    function automatic afinv_in_t mk(word_t d, word_t off, word_t sh);
        word_t [11:0] w;
        for (int i = 0; i < 9; i++) w[11 - i] = (i % 4 == 0) ? d : off;
        for (int i = 0; i < 3; i++) w[i] = sh;
        return afinv_in_t'(w);
    endfunction

    task automatic send_transform(afinv_in_t x, ref bit no_gap);
        int gap;
        if ($urandom_range(0, 15) == 0) no_gap = !no_gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= x;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        afinv_in_t directed[$];
        bit no_gap;
        no_gap = 0;
        s_valid = 0;
        s_data = '0;
        aresetn = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        directed.push_back(mk(word_t'(1 << FRAC), 0, 0));
        directed.push_back(mk(0, 0, 0));
        directed.push_back(mk(word_t'(POS_LIM), word_t'(POS_LIM), word_t'(POS_LIM)));
        directed.push_back(mk(word_t'(NEG_LIM), word_t'(NEG_LIM), word_t'(NEG_LIM)));
        directed.push_back(mk(word_t'(NEG_LIM), 0, word_t'(POS_LIM)));
        directed.push_back(mk(word_t'(POS_LIM), 0, word_t'(NEG_LIM)));
        directed.push_back(mk(1, 0, word_t'(POS_LIM)));
        directed.push_back(mk(-1, 0, word_t'(NEG_LIM)));
        directed.push_back(mk(word_t'(2 << FRAC), 0, word_t'(3 << FRAC)));
        directed.push_back(mk(word_t'(-(1 << FRAC)), 1, -1));
        directed.push_back(mk(word_t'(3 << FRAC), word_t'(1 << FRAC), word_t'(1 << FRAC)));
        directed.push_back(mk(word_t'(3), word_t'(1), word_t'(7)));
        directed.push_back(mk(word_t'(1 << FRAC), word_t'(1 << FRAC), 5));
        directed.push_back(mk(word_t'(POS_LIM), word_t'(NEG_LIM), 1));
        directed.push_back(mk(word_t'(1 << 30), word_t'(-(1 << 29)), word_t'(1 << 30)));
        foreach (directed[i]) send_transform(directed[i], no_gap);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                // drain the pipeline before continuing
                s_valid <= 1'b0;
                while (sb.pending() != 0) @(negedge aclk);
            end
            send_transform(random_transform(), no_gap);
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) $display("affine_matrix_inverse test passed");
        else $display("affine_matrix_inverse test failed");
        $finish;
    end

    initial begin
        bit no_stall;
        int stall;
        no_stall = 0;
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 15) == 0) no_stall = !no_stall;
            stall = no_stall ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        #5ms;
        $display("affine_matrix_inverse test failed");
        $finish;
    end

endmodule
